### rtl/core/mica_pkg.sv
// ----------------------------------------------------------------------------
// mica_pkg
// shared types, codes and helpers for the mmio instruction completion alu
// ----------------------------------------------------------------------------
package mica_pkg;

    localparam int NUM_REGS = 16;
    localparam int IDX_W    = 5;
    localparam int PHYS_W   = 4;

    localparam logic [IDX_W-1:0] FLAG_SLOT = 5'h10;

    // function codes
    localparam logic [3:0] FN_LOAD  = 4'd0;
    localparam logic [3:0] FN_MOV   = 4'd1;
    localparam logic [3:0] FN_MOVZX = 4'd2;
    localparam logic [3:0] FN_MOVSX = 4'd3;
    localparam logic [3:0] FN_AND   = 4'd4;
    localparam logic [3:0] FN_OR    = 4'd5;
    localparam logic [3:0] FN_XOR   = 4'd6;
    localparam logic [3:0] FN_CMP   = 4'd7;
    localparam logic [3:0] FN_TEST  = 4'd8;
    localparam logic [3:0] FN_BT    = 4'd9;
    localparam logic [3:0] FN_MOVS  = 4'd10;
    localparam logic [3:0] FN_STOS  = 4'd11;
    localparam logic [3:0] FN_READ  = 4'd12;

    // source kinds
    localparam logic [1:0] SK_REG = 2'd0;
    localparam logic [1:0] SK_IMM = 2'd1;
    localparam logic [1:0] SK_MEM = 2'd2;
    localparam logic [1:0] SK_BAD = 2'd3;

    // size codes
    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_WORD = 2'd1;
    localparam logic [1:0] SZ_LONG = 2'd2;
    localparam logic [1:0] SZ_QUAD = 2'd3;

    // flag bit positions
    localparam int FL_CF = 0;
    localparam int FL_PF = 1;
    localparam int FL_AF = 2;
    localparam int FL_ZF = 3;
    localparam int FL_SF = 4;
    localparam int FL_OF = 5;

    localparam logic [PHYS_W-1:0] REG_CNT = 4'd1;
    localparam logic [PHYS_W-1:0] REG_SRC = 4'd6;
    localparam logic [PHYS_W-1:0] REG_DST = 4'd7;

    typedef logic [NUM_REGS-1:0][63:0] gp_file_t;

    typedef struct packed {
        logic [63:0]       result_value;
        logic [IDX_W-1:0]  result_index;
        logic              wrote;
        logic [5:0]        flags;
        logic              error;
        logic              gp_we;
        logic [PHYS_W-1:0] gp_idx;
        logic [63:0]       gp_val;
        logic              str_we;
        logic              src_we;
        logic              cnt_we;
        logic [63:0]       src_val;
        logic [63:0]       dst_val;
        logic [63:0]       cnt_val;
        logic              flags_we;
    } alu_res_t;

    function automatic logic [63:0] size_mask(input logic [1:0] code);
        logic [63:0] m;
        case (code)
            SZ_BYTE: m = 64'h0000_0000_0000_00FF;
            SZ_WORD: m = 64'h0000_0000_0000_FFFF;
            SZ_LONG: m = 64'h0000_0000_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic size_msb(input logic [1:0] code, input logic [63:0] v);
        logic b;
        case (code)
            SZ_BYTE: b = v[7];
            SZ_WORD: b = v[15];
            SZ_LONG: b = v[31];
            default: b = v[63];
        endcase
        return b;
    endfunction

endpackage

### rtl/core/mmio_instruction_completion_alu_unit.sv
// ----------------------------------------------------------------------------
// mmio_instruction_completion_alu_unit
// register and flag write-back for an x86 instruction completed by a device
// ----------------------------------------------------------------------------
//  channel  | dir | bus                          | contents
//  s_axis   | in  | s_tvalid/s_tready/s_tdata    | one instruction completion item
//  m_axis   | out | m_tvalid/m_tready/m_tdata    | one result per item
//
//  each item is decoded, executed and written into the register file in the
//  cycle it is accepted; its result sits in the output register from the next cycle
//  sustained rate is one item per cycle while m_tready is high, set by the single
//  alu pass feeding the register file and output register
//  the input is taken whenever the output register is empty or being drained
//  aresetn (synchronous, active low) clears the registers, flags and m_tvalid
// ----------------------------------------------------------------------------
module mmio_instruction_completion_alu_unit
    import mica_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    // s_tdata from bit 0: func[4], src_kind[2], src_size[2], dst_size[2],
    // reg_index[5], mem_data[64], imm_value[64], dir_down[1], repeat_req[1],
    // rep_count[32], elem_size[2], zero fill[5]
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [183:0] s_tdata,
    // m_tdata from bit 0: result_value[64], result_index[5], wrote[1],
    // flags_out[6], error[1], zero fill[3]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [79:0]  m_tdata
);

    gp_file_t    regs_reg;
    logic [5:0]  flags_reg;
    logic        m_tvalid_reg;
    logic [79:0] m_tdata_reg;
    logic [79:0] m_tdata_next;
    alu_res_t    res;
    logic        s_xfer;

    // accept while the output register is free or draining this cycle
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_xfer   = s_tvalid && s_tready;

    mica_alu u_alu (
        .func       (s_tdata[3:0]),
        .src_kind   (s_tdata[5:4]),
        .src_size   (s_tdata[7:6]),
        .dst_size   (s_tdata[9:8]),
        .reg_index  (s_tdata[14:10]),
        .mem_data   (s_tdata[78:15]),
        .imm_value  (s_tdata[142:79]),
        .dir_down   (s_tdata[143]),
        .repeat_req (s_tdata[144]),
        .rep_count  (s_tdata[176:145]),
        .elem_size  (s_tdata[178:177]),
        .regs       (regs_reg),
        .flags      (flags_reg),
        .res        (res)
    );

    assign m_tdata_next = {3'd0, res.error, res.flags, res.wrote,
                           res.result_index, res.result_value};

    // architectural state update on each accepted transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg  <= '0;
            flags_reg <= '0;
        end else if (s_xfer) begin
            if (res.flags_we) begin
                flags_reg <= res.flags;
            end
            if (res.gp_we) begin
                regs_reg[res.gp_idx] <= res.gp_val;
            end
            if (res.str_we) begin
                regs_reg[REG_DST] <= res.dst_val;
                if (res.src_we) begin
                    regs_reg[REG_SRC] <= res.src_val;
                end
                if (res.cnt_we) begin
                    regs_reg[REG_CNT] <= res.cnt_val;
                end
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_xfer) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef NO_ASSERTIONS
    // a rejected item reports no write and no register
    a_err_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[76] |-> !m_tdata[69] && m_tdata[68:0] == 69'd0)
        else $error("error result carries write information");

    // a result held back must not be overwritten by a new transfer
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while result stalled");

    // flags only change on an accepted transfer
    a_flags_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_xfer |=> $stable(flags_reg))
        else $error("flags changed without a transfer");

    // reset leaves the output channel empty
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");
`endif

endmodule

### rtl/core/mica_alu.sv
// ----------------------------------------------------------------------------
// mica_alu
// operand decode, alu, flag logic and register write selection for one item
// ----------------------------------------------------------------------------
module mica_alu
    import mica_pkg::*;
(
    input  logic [3:0]  func,
    input  logic [1:0]  src_kind,
    input  logic [1:0]  src_size,
    input  logic [1:0]  dst_size,
    input  logic [4:0]  reg_index,
    input  logic [63:0] mem_data,
    input  logic [63:0] imm_value,
    input  logic        dir_down,
    input  logic        repeat_req,
    input  logic [31:0] rep_count,
    input  logic [1:0]  elem_size,
    input  gp_file_t    regs,
    input  logic [5:0]  flags,
    output alu_res_t    res
);

    logic [1:0]        lsz;
    logic              loc_ok;
    logic [PHYS_W-1:0] phys;
    logic              hi_byte;
    logic [63:0]       rd_full;
    logic [63:0]       rd_sized;
    logic [63:0]       src_v;
    logic [63:0]       ext_v;
    logic [63:0]       put_val;
    logic [1:0]        put_sz;
    logic [63:0]       put_res;
    logic [63:0]       logic_res;
    logic [63:0]       cmp_a;
    logic [63:0]       cmp_b;
    logic [63:0]       cmp_res;
    logic [63:0]       szp_in;
    logic [5:0]        szp;
    logic [63:0]       delta;
    logic [5:0]        bt_off;
    logic              idx_reg;

    // operand locate, byte indices 4..7 name bits 15:8 of registers 0..3
    always_comb begin
        lsz = (func == FN_MOVZX || func == FN_MOVSX) ? dst_size : src_size;
        hi_byte = 1'b0;
        phys = reg_index[PHYS_W-1:0];
        if (lsz == SZ_BYTE) begin
            loc_ok = (reg_index < 5'd8);
            hi_byte = reg_index[2];
            phys = {2'b00, reg_index[1:0]};
        end else begin
            loc_ok = (reg_index < 5'(NUM_REGS));
        end
    end

    assign idx_reg  = (reg_index < 5'(NUM_REGS));
    assign rd_full  = regs[phys];
    assign rd_sized = (hi_byte ? (rd_full >> 8) : rd_full) & size_mask(src_size);
    assign src_v    = (src_kind == SK_IMM) ? imm_value : rd_sized;

    // zero or sign extension for movzx / movsx
    always_comb begin
        ext_v = mem_data & size_mask(src_size);
        if (func == FN_MOVSX && size_msb(src_size, ext_v)) begin
            ext_v = ext_v | ~size_mask(src_size);
        end
    end

    always_comb begin
        case (func)
            FN_OR:   logic_res = mem_data | src_v;
            FN_XOR:  logic_res = mem_data ^ src_v;
            default: logic_res = mem_data & src_v;
        endcase
    end

    // cmp order swaps for a memory source
    assign cmp_a   = (src_kind == SK_MEM) ? src_v : mem_data;
    assign cmp_b   = (src_kind == SK_MEM) ? mem_data : src_v;
    assign cmp_res = cmp_a - cmp_b;

    assign szp_in = (func == FN_CMP) ? cmp_res : logic_res;

    always_comb begin
        szp = '0;
        szp[FL_ZF] = ((szp_in & size_mask(src_size)) == 64'd0);
        szp[FL_SF] = size_msb(src_size, szp_in);
        szp[FL_PF] = ~^szp_in[7:0];
    end

    // register merge at the write size
    always_comb begin
        put_sz  = (func == FN_MOVZX || func == FN_MOVSX) ? dst_size : src_size;
        case (func)
            FN_MOV:              put_val = mem_data;
            FN_MOVZX, FN_MOVSX:  put_val = ext_v;
            default:             put_val = logic_res;
        endcase
        case (put_sz)
            SZ_BYTE: begin
                if (hi_byte) begin
                    put_res = {rd_full[63:16], put_val[7:0], rd_full[7:0]};
                end else begin
                    put_res = {rd_full[63:8], put_val[7:0]};
                end
            end
            SZ_WORD: put_res = {rd_full[63:16], put_val[15:0]};
            SZ_LONG: put_res = {32'd0, put_val[31:0]};
            default: put_res = put_val;
        endcase
    end

    assign delta  = {32'd0, rep_count} << elem_size;
    assign bt_off = rd_sized[5:0] & 6'((8 << src_size) - 1);

    always_comb begin
        res = '0;
        res.flags = flags;
        case (func)
            FN_LOAD, FN_READ: begin
                if (reg_index == FLAG_SLOT) begin
                    if (func == FN_LOAD) begin
                        res.flags    = mem_data[5:0];
                        res.flags_we = 1'b1;
                        res.wrote    = 1'b1;
                    end
                    res.result_value = {58'd0, res.flags};
                    res.result_index = FLAG_SLOT;
                end else if (idx_reg) begin
                    if (func == FN_LOAD) begin
                        res.gp_we        = 1'b1;
                        res.gp_idx       = reg_index[PHYS_W-1:0];
                        res.gp_val       = mem_data;
                        res.wrote        = 1'b1;
                        res.result_value = mem_data;
                    end else begin
                        res.result_value = regs[reg_index[PHYS_W-1:0]];
                    end
                    res.result_index = reg_index;
                end else begin
                    res.error = 1'b1;
                end
            end
            FN_MOV, FN_MOVZX, FN_MOVSX: begin
                if (!loc_ok || (func != FN_MOV && src_size == SZ_QUAD)) begin
                    res.error = 1'b1;
                end else begin
                    res.gp_we        = 1'b1;
                    res.gp_idx       = phys;
                    res.gp_val       = put_res;
                    res.wrote        = 1'b1;
                    res.result_value = put_res;
                    res.result_index = {1'b0, phys};
                end
            end
            FN_AND, FN_OR, FN_XOR, FN_CMP, FN_TEST: begin
                if (src_kind == SK_BAD || (src_kind != SK_IMM && !loc_ok)) begin
                    res.error = 1'b1;
                end else if (func == FN_CMP) begin
                    res.flags_we = 1'b1;
                    res.flags = szp;
                    res.flags[FL_CF] = (cmp_b & size_mask(src_size)) >
                                       (cmp_a & size_mask(src_size));
                    res.flags[FL_OF] = size_msb(src_size,
                                                (cmp_a ^ cmp_b) & (cmp_a ^ cmp_res));
                    res.flags[FL_AF] = cmp_a[4] ^ cmp_b[4] ^ cmp_res[4];
                end else begin
                    res.flags_we = 1'b1;
                    res.flags = szp;
                    res.flags[FL_AF] = flags[FL_AF];
                    if (src_kind == SK_MEM && func != FN_TEST) begin
                        res.gp_we        = 1'b1;
                        res.gp_idx       = phys;
                        res.gp_val       = put_res;
                        res.wrote        = 1'b1;
                        res.result_value = put_res;
                        res.result_index = {1'b0, phys};
                    end
                end
            end
            FN_BT: begin
                if (!loc_ok) begin
                    res.error = 1'b1;
                end else begin
                    res.flags_we = 1'b1;
                    res.flags[FL_CF] = mem_data[bt_off];
                end
            end
            FN_MOVS, FN_STOS: begin
                res.str_we  = 1'b1;
                res.src_we  = (func == FN_MOVS);
                res.cnt_we  = repeat_req;
                res.src_val = dir_down ? regs[REG_SRC] - delta : regs[REG_SRC] + delta;
                res.dst_val = dir_down ? regs[REG_DST] - delta : regs[REG_DST] + delta;
                res.cnt_val = regs[REG_CNT] - {32'd0, rep_count};
                res.wrote   = 1'b1;
                res.result_value = res.dst_val;
                res.result_index = {1'b0, REG_DST};
            end
            default: begin
                res.error = 1'b1;
            end
        endcase
    end

endmodule
